// File: sv/serial_frame_checksum_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Serial frame checksum parser: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_CHECKSUM_PARSER_UNIT_DEFINES_SVH
`define SERIAL_FRAME_CHECKSUM_PARSER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define SFCP_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("sfcp assertion failed");

// Condition in one cycle that implies another in the next cycle
`define SFCP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("sfcp assertion failed");

`endif

// File: sv/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg
// Types and constants shared by the serial frame checksum parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfcp_pkg;

  // Framing characters
  localparam logic [7:0] START_MARK = 8'h3A;  // ':'
  localparam logic [7:0] END_MARK   = 8'h0A;  // newline
  localparam logic [7:0] ASCII_ZERO = 8'h30;  // '0'

  localparam logic [7:0] CKSUM_RESET = 8'd85;

  // Result field widths
  localparam int unsigned LEN_W = 6;
  localparam int unsigned IDX_W = 5;
  // Frame length carried in a job, wide enough for the largest data store
  localparam int unsigned JOB_CNT_W = 7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_REG,
    PH_FLAGS,
    PH_DATA
  } phase_e;

  typedef enum logic {
    BK_IDLE,
    BK_STREAM
  } back_e;

  // One finished frame handed from the parser to the emitter
  typedef struct packed {
    logic                 err;
    logic [7:0]           cmd;
    logic [7:0]           reg_addr;
    logic [7:0]           flags;
    logic [JOB_CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic             status;
    logic [7:0]       command_code;
    logic [7:0]       register_addr;
    logic [7:0]       flag_bits;
    logic [LEN_W-1:0] data_length;
    logic             data_valid;
    logic [IDX_W-1:0] data_index;
    logic [7:0]       data_byte;
    logic             last;
  } result_t;

  // Queue status seen by the parser
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// File: sv/sfcp_if.sv
// ----------------------------------------------------------------------------
// sfcp channel interfaces
// Valid/ready channels for received bytes, results and the config write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcp_out_if import sfcp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             status;
  logic [7:0]       command_code;
  logic [7:0]       register_addr;
  logic [7:0]       flag_bits;
  logic [LEN_W-1:0] data_length;
  logic             data_valid;
  logic [IDX_W-1:0] data_index;
  logic [7:0]       data_byte;
  logic             last;

  modport source (
    output valid, output status, output command_code, output register_addr,
    output flag_bits, output data_length, output data_valid, output data_index,
    output data_byte, output last, input ready
  );
  modport sink (
    input valid, input status, input command_code, input register_addr,
    input flag_bits, input data_length, input data_valid, input data_index,
    input data_byte, input last, output ready
  );
endinterface

interface sfcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sum_target;

  modport source (output valid, output sum_target, input ready);
  modport sink   (input valid, input sum_target, output ready);
endinterface

// File: sv/sfcp_ram.sv
// ----------------------------------------------------------------------------
// sfcp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sfcp_job_queue.sv
// ----------------------------------------------------------------------------
// sfcp_job_queue
// Two-entry queue of finished frames between the parser and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_job_queue import sfcp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o        = slot_q[rd_ptr_q];
  assign stat_o.empty = (fill_q == 2'd0);
  assign stat_o.full  = (fill_q == 2'd2);

endmodule

// File: sv/sfcp_front.sv
// ----------------------------------------------------------------------------
// sfcp_front
// Frame parser: takes bytes, tracks the header, sums and stores data bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_front import sfcp_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 32,
  parameter int unsigned CW = $clog2(DATA_DEPTH + 1),
  parameter int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfcp_in_if.sink       rx,
  sfcp_cfg_if.sink      cfg,
  input  q_stat_t       q_stat_i,
  input  logic          back_idle_i,
  output logic          push_o,
  output job_t          job_o,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o
);

  phase_e        phase_q, phase_d;
  logic [7:0]    sum_q, sum_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [7:0]    reg_q, reg_d;
  logic [7:0]    flg_q, flg_d;
  logic [7:0]    target_q;
  logic          accept;
  logic [7:0]    cmd_val;

  // Config register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= CKSUM_RESET;
    end else if (cfg.valid) begin
      target_q <= cfg.sum_target;
    end
  end

  // Data bytes wait until the store is free of the previous frame
  always_comb begin
    unique case (phase_q) inside
      PH_IDLE, PH_CMD, PH_REG, PH_FLAGS: rx.ready = 1'b1;
      default:                           rx.ready = back_idle_i && q_stat_i.empty;
    endcase
  end

  assign accept  = rx.valid && rx.ready;
  assign cmd_val = rx.rx_byte - ASCII_ZERO;

  // Parse step
  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    reg_d     = reg_q;
    flg_d     = flg_q;
    push_o    = 1'b0;
    wr_en_o   = 1'b0;
    wr_addr_o = cnt_q[AW-1:0];
    wr_data_o = rx.rx_byte;
    job_o     = '{err: 1'b1, cmd: cmd_q, reg_addr: reg_q, flags: flg_q,
                  count: JOB_CNT_W'(cnt_q)};
    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx.rx_byte == START_MARK) begin
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_d   = cmd_val;
          sum_d   = sum_q + cmd_val;
          phase_d = PH_REG;
        end
        PH_REG: begin
          reg_d   = rx.rx_byte;
          sum_d   = sum_q + rx.rx_byte;
          phase_d = PH_FLAGS;
        end
        PH_FLAGS: begin
          flg_d   = rx.rx_byte;
          sum_d   = sum_q + rx.rx_byte;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (rx.rx_byte == END_MARK) begin
            push_o    = 1'b1;
            job_o.err = (sum_q != target_q);
            phase_d   = PH_IDLE;
          end else if (cnt_q >= CW'(DATA_DEPTH)) begin
            // overflow: error result, frame dropped
            push_o  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            wr_en_o = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            sum_d   = sum_q + rx.rx_byte;
          end
        end
        default: begin
          push_o  = 1'b1;
          phase_d = PH_IDLE;
        end
      endcase
      // back to idle clears the frame
      if (phase_d == PH_IDLE) begin
        sum_d = '0;
        cnt_d = '0;
        cmd_d = '0;
        reg_d = '0;
        flg_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      cmd_q   <= '0;
      reg_q   <= '0;
      flg_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
      reg_q   <= reg_d;
      flg_q   <= flg_d;
    end
  end

endmodule

// File: sv/sfcp_back.sv
// ----------------------------------------------------------------------------
// sfcp_back
// Emitter: a queued frame gives a result per data byte, one if none or error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcp_back import sfcp_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 32,
  parameter int unsigned CW = $clog2(DATA_DEPTH + 1),
  parameter int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  job_t          job_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  output logic          idle_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  logic [7:0]    rdata_i,
  sfcp_out_if.source    res
);

  back_e         state_q, state_d;
  job_t          job_q, job_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] n_q, n_d;
  result_t       out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic [CW:0]   kp1;
  logic          is_last;
  logic [CW-1:0] job_n;

  assign out_free = !out_valid_q || res.ready;
  assign kp1      = {1'b0, k_q} + 1'b1;
  assign is_last  = (kp1 >= {1'b0, n_q});
  assign job_n    = CW'(job_i.count);
  assign idle_o   = (state_q == BK_IDLE);

  // Emitter sequencer
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    k_d         = k_q;
    n_d         = n_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res.ready;
    pop_o       = 1'b0;
    re_o        = 1'b0;
    raddr_o     = k_q[AW-1:0];
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (job_i.err) begin
            if (out_free) begin
              pop_o        = 1'b1;
              out_d        = '0;
              out_d.status = 1'b1;
              out_d.last   = 1'b1;
              out_valid_d  = 1'b1;
            end
          end else if (job_n == '0) begin
            // frame without data: one header-only result
            if (out_free) begin
              pop_o               = 1'b1;
              out_d               = '0;
              out_d.command_code  = job_i.cmd;
              out_d.register_addr = job_i.reg_addr;
              out_d.flag_bits     = job_i.flags;
              out_d.last          = 1'b1;
              out_valid_d         = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            job_d   = job_i;
            n_d     = job_n;
            k_d     = '0;
            re_o    = 1'b1;
            raddr_o = '0;
            state_d = BK_STREAM;
          end
        end
      end
      BK_STREAM: begin
        if (out_free) begin
          out_d.status        = 1'b0;
          out_d.command_code  = job_q.cmd;
          out_d.register_addr = job_q.reg_addr;
          out_d.flag_bits     = job_q.flags;
          out_d.data_length   = LEN_W'(n_q);
          out_d.data_valid    = 1'b1;
          out_d.data_index    = IDX_W'(k_q);
          out_d.data_byte     = rdata_i;
          out_d.last          = is_last;
          out_valid_d         = 1'b1;
          if (is_last) begin
            state_d = BK_IDLE;
          end else begin
            // prefetch the next byte
            k_d     = kp1[CW-1:0];
            re_o    = 1'b1;
            raddr_o = kp1[AW-1:0];
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    k_q   <= k_d;
    n_q   <= n_d;
    out_q <= out_d;
  end

  // Output channel
  assign res.valid         = out_valid_q;
  assign res.status        = out_q.status;
  assign res.command_code  = out_q.command_code;
  assign res.register_addr = out_q.register_addr;
  assign res.flag_bits     = out_q.flag_bits;
  assign res.data_length   = out_q.data_length;
  assign res.data_valid    = out_q.data_valid;
  assign res.data_index    = out_q.data_index;
  assign res.data_byte     = out_q.data_byte;
  assign res.last          = out_q.last;

endmodule

// File: sv/serial_frame_checksum_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_checksum_parser_unit
// Parses ':'-framed serial byte frames and emits checked results.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i   : one received byte per word. Bytes outside a frame are dropped
//            until ':'; then command, register, flags, data bytes, newline.
//   res_o  : result words. A good frame gives one word per data byte (or one
//            header-only word when it has no data), last set on the final one.
//            A checksum mismatch or data overrun gives one word with status 1.
//   cfg_i  : writes sum_target (reset value 85); always ready.
// Throughput: one byte per cycle while rx_i is ready. The next frame's header
//   is taken while results drain, but its first data-phase byte waits until
//   the queue is empty and the emitter has loaded its final word.
// Path: a single-word result passes from the job queue into the emitter's
//   output register; the first word of a frame with data also passes through
//   the registered read of the data store. The rest follow one per cycle
//   while res_o is ready.
// A stalled res_o holds its word and, through the emitter, holds off the data
//   bytes of the next frame; at most one finished frame waits in the queue.
//   Reset returns the parser to idle, empties the queue and drops any pending
//   result; the data store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_checksum_parser_unit import sfcp_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfcp_in_if.sink    rx_i,
  sfcp_out_if.source res_o,
  sfcp_cfg_if.sink   cfg_i
);

  localparam int unsigned CW = $clog2(DATA_DEPTH + 1);
  localparam int unsigned AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  q_stat_t       q_stat;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head_job;
  logic          back_idle;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  sfcp_front #(
    .DATA_DEPTH (DATA_DEPTH),
    .CW         (CW),
    .AW         (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .cfg         (cfg_i),
    .q_stat_i    (q_stat),
    .back_idle_i (back_idle),
    .push_o      (push),
    .job_o       (push_job),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  sfcp_job_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  sfcp_ram #(
    .WIDTH (8),
    .DEPTH (DATA_DEPTH),
    .AW    (AW)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sfcp_back #(
    .DATA_DEPTH (DATA_DEPTH),
    .CW         (CW),
    .AW         (AW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .q_empty_i (q_stat.empty),
    .pop_o     (pop),
    .idle_o    (back_idle),
    .re_o      (rd_en),
    .raddr_o   (rd_addr),
    .rdata_i   (rd_data),
    .res       (res_o)
  );

endmodule

// File: sv/sfcp_checker.sv
// ----------------------------------------------------------------------------
// sfcp_checker
// Port-level assertions for the serial frame checksum parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_frame_checksum_parser_unit_defines.svh"

module sfcp_checker import sfcp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             status_i,
  input logic [7:0]       command_code_i,
  input logic [7:0]       register_addr_i,
  input logic [7:0]       flag_bits_i,
  input logic [LEN_W-1:0] data_length_i,
  input logic             data_valid_i,
  input logic [IDX_W-1:0] data_index_i,
  input logic [7:0]       data_byte_i,
  input logic             last_i
);

  // A stalled result word stays put
  `SFCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({status_i, command_code_i, register_addr_i, flag_bits_i, data_length_i, data_valid_i, data_index_i, data_byte_i, last_i}))

  // Error word is a lone, empty word
  `SFCP_ASSERT_ALWAYS(a_err_word, clk_i, rst_ni, !(out_valid_i && status_i) || (last_i && !data_valid_i && data_length_i == '0 && command_code_i == 8'd0))

  // A word without data is always the only one of its frame
  `SFCP_ASSERT_ALWAYS(a_nodata_last, clk_i, rst_ni, !(out_valid_i && !data_valid_i) || last_i)

endmodule

bind serial_frame_checksum_parser_unit sfcp_checker u_sfcp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .status_i        (res_o.status),
  .command_code_i  (res_o.command_code),
  .register_addr_i (res_o.register_addr),
  .flag_bits_i     (res_o.flag_bits),
  .data_length_i   (res_o.data_length),
  .data_valid_i    (res_o.data_valid),
  .data_index_i    (res_o.data_index),
  .data_byte_i     (res_o.data_byte),
  .last_i          (res_o.last)
);
